// File: src/gbfp_pkg.sv
// Shared constants and codes for the binary GPS frame parser.
`default_nettype none

package gbfp_pkg;

   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int unsigned SEEN_W      = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND = 8'h62;
   localparam logic [7:0]  ACK_CLASS   = 8'h05;
   localparam logic [7:0]  ACK_ID      = 8'h01;
   localparam logic [7:0]  UNSET_BYTE  = 8'hFF;
   localparam logic [15:0] MAX_LEN     = 16'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      ST_BUSY    = 3'd0,
      ST_MATCH   = 3'd1,
      ST_OTHER   = 3'd2,
      ST_CKERR   = 3'd3,
      ST_TOOLONG = 3'd4
   } status_type;

endpackage

`default_nettype wire

// File: src/gps_binary_frame_parser_top.sv
// Binary GPS frame parser: sync hunt, header decode, Fletcher-8 check, ACK/NAK match.
//
// Takes one received byte per req_ transfer and returns one status per byte on rsp_.
// An item passes through the input register, then the frame state update into the result
// register. One byte can be accepted every cycle while rsp_ is not stalled; while a
// result is held on a stalled rsp_ channel the input register takes a further byte only
// when it is empty. Status is 0 while a frame is in progress, 1 for a good frame
// of the acknowledge class that matches the expected kind (csr_wr_data selects NAK),
// 2 for any other good frame, 3 for a checksum error and 4 for a length over
// MAX_PAYLOAD. After a finished or rejected frame the parser hunts for sync again.
// Write the expected kind only while the block is idle.
`default_nettype none

module gps_binary_frame_parser_top
   import gbfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_frame_status,
   output logic [7:0]       rsp_msg_class,
   output logic [7:0]       rsp_msg_id,
   output logic [15:0]      rsp_payload_len,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   // input register
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;

   // frame state
   phase_type         phase_ff, phase_in;
   logic [7:0]        class_ff, class_in;
   logic [7:0]        id_ff, id_in;
   logic [15:0]       length_ff, length_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [7:0]        rx_sum_a_ff, rx_sum_a_in;
   logic              expect_nak_ff;

   // result register
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [7:0]        rsp_class_ff;
   logic [7:0]        rsp_id_ff;
   logic [15:0]       rsp_length_ff;

   logic              advance;
   logic              step;
   logic              finish;
   logic [7:0]        add_a;
   logic [7:0]        add_b;
   logic [SEEN_W-1:0] seen_inc;
   logic [15:0]       len_full;
   logic              is_nak;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign add_a    = sum_a_ff + in_byte_ff;
   assign add_b    = sum_b_ff + add_a;
   assign seen_inc = seen_ff + SEEN_W'(1);
   assign len_full = {in_byte_ff, length_ff[7:0]};
   assign is_nak   = (id_ff != ACK_ID);

   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      seen_in     = seen_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      rx_sum_a_in = rx_sum_a_ff;
      status_in   = ST_BUSY;
      finish      = 1'b0;
      unique case (phase_ff)
         PH_SYNC1: begin
            if (in_byte_ff == SYNC_FIRST) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            // a bad second sync byte is dropped, not rechecked as a first
            phase_in = (in_byte_ff == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
         end
         PH_CLASS: begin
            class_in = in_byte_ff;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = in_byte_ff;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'h00, in_byte_ff};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = len_full;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            seen_in   = '0;
            if (len_full > MAX_LEN) begin
               status_in = ST_TOOLONG;
               finish    = 1'b1;
            end else if (len_full == 16'h0000) begin
               phase_in = PH_CK_A;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            seen_in  = seen_inc;
            if (16'(seen_inc) >= length_ff) phase_in = PH_CK_A;
         end
         PH_CK_A: begin
            rx_sum_a_in = in_byte_ff;
            phase_in    = PH_CK_B;
         end
         PH_CK_B: begin
            finish = 1'b1;
            if (rx_sum_a_ff != sum_a_ff || in_byte_ff != sum_b_ff) begin
               status_in = ST_CKERR;
            end else if (class_ff == ACK_CLASS && is_nak == expect_nak_ff) begin
               status_in = ST_MATCH;
            end else begin
               status_in = ST_OTHER;
            end
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   // restart hunt: state back to reset values when no frame is open
   logic hunt;
   assign hunt = finish || phase_in == PH_SYNC1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         expect_nak_ff <= 1'b0;
         phase_ff      <= PH_SYNC1;
         class_ff      <= UNSET_BYTE;
         id_ff         <= UNSET_BYTE;
         length_ff     <= '0;
         seen_ff       <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         rx_sum_a_ff   <= '0;
      end else begin
         if (csr_wr_en) expect_nak_ff <= csr_wr_data;
         if (req_ready) begin
            in_valid_ff <= req_valid;
            in_byte_ff  <= req_rx_byte;
         end
         if (advance) rsp_valid_ff <= in_valid_ff;
         if (step) begin
            status_ff     <= status_in;
            rsp_class_ff  <= phase_in == PH_SYNC1 && !finish ? UNSET_BYTE : class_in;
            rsp_id_ff     <= phase_in == PH_SYNC1 && !finish ? UNSET_BYTE : id_in;
            rsp_length_ff <= phase_in == PH_SYNC1 && !finish ? 16'h0000 : length_in;
            if (hunt) begin
               phase_ff    <= PH_SYNC1;
               class_ff    <= UNSET_BYTE;
               id_ff       <= UNSET_BYTE;
               length_ff   <= '0;
               seen_ff     <= '0;
               sum_a_ff    <= '0;
               sum_b_ff    <= '0;
               rx_sum_a_ff <= '0;
            end else begin
               phase_ff    <= phase_in;
               class_ff    <= class_in;
               id_ff       <= id_in;
               length_ff   <= length_in;
               seen_ff     <= seen_in;
               sum_a_ff    <= sum_a_in;
               sum_b_ff    <= sum_b_in;
               rx_sum_a_ff <= rx_sum_a_in;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_msg_class    = rsp_class_ff;
   assign rsp_msg_id       = rsp_id_ff;
   assign rsp_payload_len  = rsp_length_ff;

   a_finish_hunts: assert property (@(posedge clock) disable iff (reset)
      (step && status_in != ST_BUSY) |=> phase_ff == PH_SYNC1)
      else $error("parser did not return to sync hunt after a finished frame");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SYNC1 |-> (class_ff == UNSET_BYTE && id_ff == UNSET_BYTE
                                && length_ff == 16'h0000 && sum_a_ff == 8'h00))
      else $error("frame state not cleared while hunting");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (16'(seen_ff) < length_ff && length_ff <= MAX_LEN))
      else $error("payload count out of range");

   a_toolong_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_TOOLONG) |-> rsp_length_ff > MAX_LEN)
      else $error("length error reported for an allowed length");

endmodule

`default_nettype wire

// File: test/tb_gps_binary_frame_parser_top.sv
// Self-checking testbench for the binary GPS frame parser: directed table, then random frames.
`timescale 1ns / 1ps

module tb_gps_binary_frame_parser_top
   import gbfp_pkg::*;
();

   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_BYTES = 128;
   localparam int NUM_DIRECTED = 26;

   typedef enum logic [3:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
      GET_PAYLOAD, GET_CK_A, GET_CK_B
   } parse_phase_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] len;
   } frame_report_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             typed;
      frame_report_type want;
   } directed_row_type;

   // Typed rows: hunting after reset, and the closing byte of each frame.
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{8'hB5, 1'b1, '{ST_BUSY, 8'hFF, 8'hFF, 16'h0000}},
      '{8'hB5, 1'b1, '{ST_BUSY, 8'hFF, 8'hFF, 16'h0000}},   // bad second sync
      '{8'h62, 1'b1, '{ST_BUSY, 8'hFF, 8'hFF, 16'h0000}},   // not taken as sync
      '{8'hB5, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h62, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h05, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h01, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h01, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h07, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h20, 1'b1, '{ST_MATCH, 8'h05, 8'h01, 16'h0001}},
      '{8'hB5, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h62, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'hFF, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'hFF, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b1, '{ST_CKERR, 8'hFF, 8'hFF, 16'h0000}},
      '{8'hB5, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h62, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'h00, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'hFF, 1'b0, '{ST_BUSY, 8'h00, 8'h00, 16'h0000}},
      '{8'hFF, 1'b1, '{ST_TOOLONG, 8'h00, 8'h00, 16'hFFFF}}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_frame_status;
   logic [7:0]  rsp_msg_class;
   logic [7:0]  rsp_msg_id;
   logic [15:0] rsp_payload_len;
   logic        csr_wr_en;
   logic        csr_wr_data;

   gps_binary_frame_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_msg_class    (rsp_msg_class),
      .rsp_msg_id       (rsp_msg_id),
      .rsp_payload_len  (rsp_payload_len),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Parser state as the predictor sees it
   parse_phase_type phase_m;
   logic [7:0]      class_m;
   logic [7:0]      id_m;
   logic [15:0]     length_m;
   logic [15:0]     seen_m;
   logic [7:0]      sum_a_m;
   logic [7:0]      sum_b_m;
   logic [7:0]      rx_sum_a_m;
   logic            expect_nak_m;

   frame_report_type pending_reports [$];
   int  errors = 0;
   int  bytes_sent = 0;
   int  statuses_checked = 0;
   int  closed_by_status [8];
   bit  calm = 1'b0;
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;

   always #2 clock = ~clock;

   function automatic void clear_frame();
      phase_m    = HUNT_SYNC1;
      class_m    = UNSET_BYTE;
      id_m       = UNSET_BYTE;
      length_m   = '0;
      seen_m     = '0;
      sum_a_m    = '0;
      sum_b_m    = '0;
      rx_sum_a_m = '0;
   endfunction

   function automatic void add_to_sum(input logic [7:0] b);
      sum_a_m = sum_a_m + b;
      sum_b_m = sum_b_m + sum_a_m;
   endfunction

   function automatic frame_report_type next_frame_report(input logic [7:0] b);
      frame_report_type r;
      logic             done;
      r.status = ST_BUSY;
      done = 1'b0;
      case (phase_m)
         HUNT_SYNC1: begin
            if (b == SYNC_FIRST) phase_m = HUNT_SYNC2;
         end
         HUNT_SYNC2: begin
            if (b == SYNC_SECOND) phase_m = GET_CLASS;
            else clear_frame();
         end
         GET_CLASS: begin
            class_m = b;
            add_to_sum(b);
            phase_m = GET_ID;
         end
         GET_ID: begin
            id_m = b;
            add_to_sum(b);
            phase_m = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            length_m = {8'h00, b};
            add_to_sum(b);
            phase_m = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            length_m[15:8] = b;
            add_to_sum(b);
            seen_m = '0;
            if (length_m > MAX_LEN) begin
               r.status = ST_TOOLONG;
               done = 1'b1;
            end else if (length_m == 16'd0) begin
               phase_m = GET_CK_A;
            end else begin
               phase_m = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            add_to_sum(b);
            seen_m = seen_m + 16'd1;
            if (seen_m >= length_m) phase_m = GET_CK_A;
         end
         GET_CK_A: begin
            rx_sum_a_m = b;
            phase_m = GET_CK_B;
         end
         GET_CK_B: begin
            done = 1'b1;
            if (rx_sum_a_m != sum_a_m || b != sum_b_m)
               r.status = ST_CKERR;
            else if (class_m == ACK_CLASS)
               r.status = ((id_m != ACK_ID) == expect_nak_m) ? ST_MATCH : ST_OTHER;
            else
               r.status = ST_OTHER;
         end
         default: clear_frame();
      endcase
      r.msg_class = class_m;
      r.msg_id    = id_m;
      r.len       = length_m;
      if (done) clear_frame();
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input frame_report_type want = '0);
      frame_report_type got;
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer taken at this edge
      got = next_frame_report(b);
      if (typed) got = want;
      pending_reports = {pending_reports, got};
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input bit corrupt);
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] hdr [4];
      logic [7:0] pb;
      hdr = '{cls, id, len[7:0], len[15:8]};
      ck_a = '0;
      ck_b = '0;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      foreach (hdr[k]) begin
         ck_a = ck_a + hdr[k];
         ck_b = ck_b + ck_a;
         send_byte(hdr[k]);
      end
      if (len > MAX_LEN) return;
      for (int k = 0; k < int'(len); k++) begin
         pb = 8'($urandom);
         ck_a = ck_a + pb;
         ck_b = ck_b + ck_a;
         send_byte(pb);
      end
      if (corrupt) begin
         if ($urandom_range(1)) ck_a ^= 8'(1 << $urandom_range(7));
         else ck_b ^= 8'(1 << $urandom_range(7));
      end
      send_byte(ck_a);
      send_byte(ck_b);
   endtask

   task automatic send_random_chunk();
      int          pick;
      logic [7:0]  cls;
      logic [7:0]  id;
      logic [15:0] len;
      pick = $urandom_range(99);
      cls  = $urandom_range(1) ? ACK_CLASS : 8'($urandom);
      id   = $urandom_range(1) ? ACK_ID : 8'($urandom);
      len  = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 9)) : 16'($urandom_range(8));
      if (pick < 75) begin
         send_frame(cls, id, len, 1'b0);
      end else if (pick < 85) begin
         send_frame(cls, id, len, 1'b1);
      end else if (pick < 90) begin
         len = $urandom_range(3) == 0 ? MAX_LEN + 16'd1 : 16'($urandom_range(65535, 1025));
         send_frame(cls, id, len, 1'b0);
      end else if (pick < 94) begin
         send_byte(SYNC_FIRST);
         send_byte(8'($urandom));
      end else begin
         repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
   endtask

   // Hold the sender until every pending status has come back
   task automatic drain_pending();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_expect_nak(input logic v);
      drain_pending();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      expect_nak_m = v;
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 34);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("rsp transfer with no status pending: status %0d class %0h id %0h len %0d",
                   rsp_frame_status, rsp_msg_class, rsp_msg_id, rsp_payload_len);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            statuses_checked++;
            closed_by_status[rsp_frame_status]++;
            if (rsp_frame_status !== want.status) begin
               $error("frame_status: expected %0d, got %0d", want.status, rsp_frame_status);
               errors++;
            end
            if (rsp_msg_class !== want.msg_class) begin
               $error("msg_class: expected %0h, got %0h", want.msg_class, rsp_msg_class);
               errors++;
            end
            if (rsp_msg_id !== want.msg_id) begin
               $error("msg_id: expected %0h, got %0h", want.msg_id, rsp_msg_id);
               errors++;
            end
            if (rsp_payload_len !== want.len) begin
               $error("payload_len: expected %0d, got %0d", want.len, rsp_payload_len);
               errors++;
            end
         end
      end
   end

   initial begin
      int start;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      clear_frame();
      expect_nak_m = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_DIRECTED; r++)
         send_byte(DIRECTED[r].rx_byte, DIRECTED[r].typed, DIRECTED[r].want);

      for (int ph = 0; ph < 4; ph++) begin
         set_expect_nak(ph % 2 == 0);
         calm = (ph == 2);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            if (ph == 1 && !hold_request && bytes_sent - start > 40) hold_request = 1'b1;
            send_random_chunk();
         end
      end
      calm = 1'b0;

      drain_pending();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes, checked %0d statuses under both ACK and NAK expectation",
               bytes_sent, statuses_checked);
      $display("Frames closed: %0d matched, %0d other, %0d checksum errors, %0d too long",
               closed_by_status[ST_MATCH], closed_by_status[ST_OTHER],
               closed_by_status[ST_CKERR], closed_by_status[ST_TOOLONG]);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
